// File: sv/qrfp_pkg.sv
// ----------------------------------------------------------------------------
// QR function-pattern classifier package
// Shared types, value codes and the per-version alignment spacing table.
// ----------------------------------------------------------------------------
package qrfp_pkg;

   // Highest supported symbol version.
   localparam int MAX_VERSION = 40;

   // Most alignment centers after the fixed one at index 6.
   localparam int LANE_COUNT = 6;

   // Module value codes.
   typedef enum logic [1:0] {
      VALUE_LIGHT    = 2'd0,
      VALUE_DARK     = 2'd1,
      VALUE_FREE     = 2'd2,
      VALUE_RESERVED = 2'd3
   } value_type;

   // Classification result handed from the classifier to the output register.
   typedef struct packed {
      value_type value;
      logic      outside;
   } result_type;

   // Alignment spacing: step between centers and number of centers after index 6.
   typedef struct packed {
      logic [4:0] step;
      logic [2:0] count;
   } align_type;

   // Alignment spacing per version. Versions below 7 have only one moving
   // center, so the step does not matter there.
   function automatic align_type align_for(logic [5:0] version);
      align_type al;
      al = '0;
      unique case (version)
         6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6: al = '{step: 5'd0,  count: 3'd1};
         6'd7:                               al = '{step: 5'd16, count: 3'd2};
         6'd8:                               al = '{step: 5'd18, count: 3'd2};
         6'd9:                               al = '{step: 5'd20, count: 3'd2};
         6'd10:                              al = '{step: 5'd22, count: 3'd2};
         6'd11:                              al = '{step: 5'd24, count: 3'd2};
         6'd12:                              al = '{step: 5'd26, count: 3'd2};
         6'd13:                              al = '{step: 5'd28, count: 3'd2};
         6'd14:                              al = '{step: 5'd20, count: 3'd3};
         6'd15:                              al = '{step: 5'd22, count: 3'd3};
         6'd16, 6'd17:                       al = '{step: 5'd24, count: 3'd3};
         6'd18:                              al = '{step: 5'd26, count: 3'd3};
         6'd19, 6'd20:                       al = '{step: 5'd28, count: 3'd3};
         6'd21:                              al = '{step: 5'd22, count: 3'd4};
         6'd22, 6'd23:                       al = '{step: 5'd24, count: 3'd4};
         6'd24, 6'd25:                       al = '{step: 5'd26, count: 3'd4};
         6'd26, 6'd27:                       al = '{step: 5'd28, count: 3'd4};
         6'd28, 6'd29:                       al = '{step: 5'd24, count: 3'd5};
         6'd30, 6'd31, 6'd32:                al = '{step: 5'd26, count: 3'd5};
         6'd33, 6'd34:                       al = '{step: 5'd28, count: 3'd5};
         6'd35:                              al = '{step: 5'd24, count: 3'd6};
         6'd36, 6'd37, 6'd38:                al = '{step: 5'd26, count: 3'd6};
         6'd39, 6'd40:                       al = '{step: 5'd28, count: 3'd6};
         default:                            al = '{step: 5'd0,  count: 3'd1};
      endcase
      return al;
   endfunction

endpackage

// File: sv/qr_function_pattern_classifier.sv
// ----------------------------------------------------------------------------
// QR function-pattern classifier
// Returns the function-pattern value of one module coordinate of a QR symbol.
// ----------------------------------------------------------------------------
// The block takes one coordinate per clock unless rsp_tready stalls the
// result register, and returns whether that module is light, dark, free for
// data or reserved for format or version information in a symbol of the
// programmed version, via the input register and the result register around
// the single-pass classifier. The result register lets a new coordinate enter
// while a finished result waits. The version register resets to 1; 0 reads
// as version 1 and values above 40 read as 40. The user must write it only
// while no items are in flight; the block does not enforce it. No start-up pass.
module qr_function_pattern_classifier
   import qrfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // Version register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data,       // symbol_version

   // Coordinate stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,      // [7:0] first_index, [15:8] second_index

   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,      // [1:0] module_value, [7:2] zero
   output logic        rsp_tuser       // [0] outside_grid
);

   logic [5:0] version_ff;
   logic [5:0] eff_version;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_first_ff;
   logic [7:0] s1_second_ff;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_result_ff;

   logic       req_xfer;
   logic       rsp_advance;
   result_type result;

   // Version register: always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 6'd1;
      end else if (csr_valid && csr_ready) begin
         version_ff <= csr_data;
      end
   end

   // Clamp the version into the supported range.
   always_comb begin
      priority if (version_ff == 6'd0) begin
         eff_version = 6'd1;
      end else if (version_ff > 6'(MAX_VERSION)) begin
         eff_version = 6'(MAX_VERSION);
      end else begin
         eff_version = version_ff;
      end
   end

   // Handshake: the result register frees when empty or taken downstream,
   // and the input register frees when empty or moving into the result.
   assign rsp_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || rsp_advance;
   assign req_xfer    = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
      rsp_valid_in = rsp_advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_first_ff  <= req_tdata[7:0];
         s1_second_ff <= req_tdata[15:8];
      end
   end

   qrfp_classify u_classify (
      .version      (eff_version),
      .first_index  (s1_first_ff),
      .second_index (s1_second_ff),
      .result       (result)
   );

   // Result register payload.
   always_ff @(posedge clock) begin
      if (rsp_advance && s1_valid_ff) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_result_ff.value};
   assign rsp_tuser  = rsp_result_ff.outside;

   // An accepted coordinate always occupies the input register next cycle.
   a_req_loads: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted coordinate did not reach the input register");

   // A held coordinate is not dropped while the result side stalls.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_advance |=> s1_valid_ff)
      else $error("stalled coordinate lost from the input register");

   // A coordinate moving on shows up as a valid result.
   a_rsp_loads: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_advance |=> rsp_tvalid)
      else $error("classified coordinate did not reach the result register");

   // Out-of-grid results always carry a light value.
   a_outside_light: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == VALUE_LIGHT)
      else $error("outside result carries a nonzero value");

endmodule

// File: sv/qrfp_classify.sv
// ----------------------------------------------------------------------------
// QR function-pattern classifier core
// Combinational classification of one module coordinate for a given version.
// ----------------------------------------------------------------------------
module qrfp_classify
   import qrfp_pkg::*;
(
   input  logic [5:0]  version,       // effective version, 1 to MAX_VERSION
   input  logic [7:0]  first_index,
   input  logic [7:0]  second_index,
   output result_type  result
);

   // Nearest alignment center of one coordinate.
   typedef struct packed {
      logic       hit;
      logic       is_first;
      logic       is_last;
      logic [1:0] off;
   } near_type;

   function automatic logic [7:0] absdiff(logic [7:0] x, logic [7:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   // Centers are 6 and then last, last - step, ... going down, count of them.
   function automatic near_type find_center(logic [7:0] coord, align_type al,
                                            logic [7:0] last);
      near_type   r;
      logic [7:0] pos;
      logic [7:0] d;
      r = '0;
      d = absdiff(coord, 8'd6);
      if (d <= 8'd2) begin
         r.hit      = 1'b1;
         r.is_first = 1'b1;
         r.off      = d[1:0];
      end
      for (int m = 0; m < LANE_COUNT; m++) begin
         pos = last - 8'(8'(al.step) * 8'(m));
         d   = absdiff(coord, pos);
         if (!r.hit && (3'(m) < al.count) && (d <= 8'd2)) begin
            r.hit     = 1'b1;
            r.is_last = (m == 0);
            r.off     = d[1:0];
         end
      end
      return r;
   endfunction

   logic [7:0] a;
   logic [7:0] b;
   logic [7:0] size;
   logic [7:0] size_m4;
   logic [7:0] size_m7;
   logic [7:0] size_m8;
   logic [7:0] size_m9;
   logic [7:0] size_m11;
   align_type  al;
   near_type   near_a;
   near_type   near_b;
   logic [7:0] fd;
   logic [7:0] fda;
   logic [7:0] fdb;
   logic [1:0] ad;
   value_type  val;

   assign a     = first_index;
   assign b     = second_index;

   // Grid geometry for this version.
   assign size     = 8'd17 + {version, 2'b00};
   assign size_m4  = size - 8'd4;
   assign size_m7  = size - 8'd7;
   assign size_m8  = size - 8'd8;
   assign size_m9  = size - 8'd9;
   assign size_m11 = size - 8'd11;
   assign al       = align_for(version);

   // Alignment center search on each axis; the last center sits at size - 7.
   assign near_a = find_center(a, al, size_m7);
   assign near_b = find_center(b, al, size_m7);

   // Chebyshev distances to the finder centers, used by the finder rings.
   always_comb begin
      fda = 8'd0;
      fdb = 8'd0;
      if (a < 8'd7) begin
         fda = absdiff(a, 8'd3);
      end else begin
         fda = absdiff(a, size_m4);
      end
      if (b < 8'd7) begin
         fdb = absdiff(b, 8'd3);
      end else begin
         fdb = absdiff(b, size_m4);
      end
   end

   assign fd = (fda > fdb) ? fda : fdb;
   assign ad = (near_a.off > near_b.off) ? near_a.off : near_b.off;

   // Layers in order; a later layer overrides an earlier one.
   always_comb begin
      val = VALUE_FREE;

      // Finders: dark core and outer ring, light ring between.
      if ((a < 8'd7 && b < 8'd7) || (a < 8'd7 && b >= size_m7) ||
          (a >= size_m7 && b < 8'd7)) begin
         val = (fd == 8'd2) ? VALUE_LIGHT : VALUE_DARK;
      end

      // Separators around the three finders.
      if ((a == 8'd7 && b <= 8'd7) || (b == 8'd7 && a <= 8'd7)) val = VALUE_LIGHT;
      if ((a <= 8'd7 && b == size_m8) || (a == 8'd7 && b >= size_m8)) val = VALUE_LIGHT;
      if ((a == size_m8 && b <= 8'd7) || (a >= size_m8 && b == 8'd7)) val = VALUE_LIGHT;

      // Alignment patterns, skipping the three centers that land on finders.
      if (version >= 6'd2 && near_a.hit && near_b.hit) begin
         if (!((near_a.is_first && near_b.is_first) ||
               (near_a.is_first && near_b.is_last) ||
               (near_a.is_last && near_b.is_first))) begin
            val = (ad == 2'd1) ? VALUE_LIGHT : VALUE_DARK;
         end
      end

      // Timing lines: dark on even indexes.
      if (b == 8'd6 && a >= 8'd8 && a < size_m8) begin
         val = a[0] ? VALUE_LIGHT : VALUE_DARK;
      end
      if (a == 8'd6 && b >= 8'd8 && b < size_m8) begin
         val = b[0] ? VALUE_LIGHT : VALUE_DARK;
      end

      // The single dark module beside the lower-left finder.
      if (a == 8'd8 && b == size_m8) val = VALUE_DARK;

      // Format areas.
      if (a == 8'd8 && b <= 8'd8 && b != 8'd6) val = VALUE_RESERVED;
      if (b == 8'd8 && a <= 8'd8 && a != 8'd6) val = VALUE_RESERVED;
      if (a == 8'd8 && b >= size_m7) val = VALUE_RESERVED;
      if (b == 8'd8 && a >= size_m8) val = VALUE_RESERVED;

      // Version areas, from version 7 up.
      if (version >= 6'd7) begin
         if (a < 8'd6 && b >= size_m11 && b <= size_m9) val = VALUE_RESERVED;
         if (b < 8'd6 && a >= size_m11 && a <= size_m9) val = VALUE_RESERVED;
      end
   end

   // Out-of-grid coordinates report light with the outside flag set.
   always_comb begin
      result.outside = (a >= size) || (b >= size);
      result.value   = result.outside ? VALUE_LIGHT : val;
   end

endmodule
